// ===== rtl/dmac_pkg.sv =====
// Shared types and constants of the ISA DMA controller register model.
// No dependencies.
package dmac_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int CH_W = $clog2(NUM_CHANNELS);

   typedef enum logic [3:0] {
      CMD_CHAN_WR  = 4'd0,
      CMD_CHAN_RD  = 4'd1,
      CMD_CTL_WR   = 4'd2,
      CMD_CTL_RD   = 4'd3,
      CMD_PAGE_WR  = 4'd4,
      CMD_PAGE_RD  = 4'd5,
      CMD_HPAGE_WR = 4'd6,
      CMD_HPAGE_RD = 4'd7,
      CMD_HOLD     = 4'd8,
      CMD_RELEASE  = 4'd9,
      CMD_TICK     = 4'd10,
      CMD_POSITION = 4'd11
   } cmd_type;

   typedef enum logic [3:0] {
      CTL_COMMAND   = 4'd8,
      CTL_REQUEST   = 4'd9,
      CTL_SMASK     = 4'd10,
      CTL_MODE      = 4'd11,
      CTL_CLR_FF    = 4'd12,
      CTL_RESET     = 4'd13,
      CTL_CLR_MASK  = 4'd14,
      CTL_WR_MASK   = 4'd15
   } ctl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_TICK_RD,
      S_TICK_EX
   } state_type;

   localparam logic [7:0] UNSUPPORTED_CMD = 8'hfb;
   localparam logic [7:0] MASK_ALL        = 8'hff;
   localparam logic [0:0] CSR_WORD_SHIFT  = 1'b0;

   typedef struct packed {
      logic [15:0] base_address;
      logic [15:0] base_count;
      logic [16:0] current_address;
      logic [17:0] current_count;
      logic [7:0]  mode;
      logic [7:0]  page_low;
      logic [7:0]  page_high;
   } chan_rec_type;

   typedef struct packed {
      logic          hit;
      logic [CH_W-1:0] ch;
   } chan_sel_type;

   function automatic chan_sel_type page_map(input logic [2:0] p);
      chan_sel_type s;
      s.hit = 1'b1;
      s.ch  = '0;
      case (p)
         3'd1: s.ch = 2'd2;
         3'd2: s.ch = 2'd3;
         3'd3: s.ch = 2'd1;
         3'd7: s.ch = 2'd0;
         default: s.hit = 1'b0;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/isa_dma_controller_registers.sv =====
// Top level of the ISA DMA controller register model.
// Depends on dmac_pkg.
//
//   channel   ports                        handshake
//   request   req_command .. req_new_position  start / busy
//   result    rsp_read_byte .. rsp_last     rsp_valid strobe, one cycle
//   config    psel penable pwrite paddr ..  APB, pready tied high
//
// A bus or device item takes a channel memory read, then the update and
// write back. A tick reads the channels in turn through the single memory
// read port. Results are registered, showing in the cycle after the one that
// makes them. Reset is synchronous; the receiver cannot stall.
module isa_dma_controller_registers (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_command,
   input  logic [3:0]  req_port,
   input  logic [7:0]  req_write_byte,
   input  logic [17:0] req_new_position,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_transfer_valid,
   output logic [1:0]  rsp_transfer_channel,
   output logic [17:0] rsp_transfer_position,
   output logic [17:0] rsp_transfer_length,
   output logic [30:0] rsp_transfer_address,
   output logic        rsp_address_down,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int NCH = dmac_pkg::NUM_CHANNELS;
   localparam int CW  = dmac_pkg::CH_W;

   dmac_pkg::state_type state_ff, state_in;
   logic [3:0]  cmd_ff, cmd_in;
   logic [3:0]  port_ff, port_in;
   logic [7:0]  data_ff, data_in;
   logic [17:0] pos_ff, pos_in;
   dmac_pkg::chan_sel_type sel_ff, sel_in;
   logic [CW-1:0] scan_ff, scan_in;

   logic        ws_ff, ws_in;
   logic        toggle_ff, toggle_in;
   logic [7:0]  mask_ff, mask_in;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  cmdreg_ff, cmdreg_in;

   dmac_pkg::chan_rec_type chan_mem [NCH];
   logic [NCH-1:0] mem_ok_ff, mem_ok_in;
   dmac_pkg::chan_rec_type rd_rec_ff, rec, wr_rec;
   logic          rd_ok_ff;
   logic [CW-1:0] rd_addr;
   logic          wr_en;

   logic        v_ff, v_in, tv_ff, tv_in, dn_ff, dn_in, last_ff, last_in;
   logic [7:0]  rb_ff, rb_in;
   logic [1:0]  tc_ff, tc_in;
   logic [17:0] tp_ff, tp_in, tl_ff, tl_in;
   logic [30:0] ta_ff, ta_in;

   logic [NCH-1:0] svc;
   logic           more;
   logic [17:0]    val;
   logic [4:0]     rsh;
   logic [1:0]     ch2;
   logic [16:0]    len17;

   always_comb begin
      for (int i = 0; i < NCH; i++) begin
         svc[i] = !mask_ff[i] && status_ff[i+4];
      end
      more = 1'b0;
      for (int i = 0; i < NCH; i++) begin
         if (CW'(i) > scan_ff && svc[i]) more = 1'b1;
      end
   end

   assign rec = rd_ok_ff ? rd_rec_ff : '0;

   always_ff @(posedge clock) begin
      rd_rec_ff <= chan_mem[rd_addr];
      rd_ok_ff  <= mem_ok_ff[rd_addr];
      if (wr_en) begin
         chan_mem[sel_ff.ch] <= wr_rec;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      port_in   = port_ff;
      data_in   = data_ff;
      pos_in    = pos_ff;
      sel_in    = sel_ff;
      scan_in   = scan_ff;
      ws_in     = ws_ff;
      toggle_in = toggle_ff;
      mask_in   = mask_ff;
      status_in = status_ff;
      cmdreg_in = cmdreg_ff;
      mem_ok_in = mem_ok_ff;
      rd_addr   = scan_ff;
      wr_en     = 1'b0;
      wr_rec    = rec;
      v_in = 1'b0; tv_in = 1'b0; dn_in = 1'b0; last_in = 1'b0;
      rb_in = '0; tc_in = '0; tp_in = '0; tl_in = '0; ta_in = '0;
      val = '0;
      rsh = '0;
      ch2 = port_ff[1:0];
      len17 = 17'(rec.base_count) + 17'd1;

      if (psel && penable && pwrite && paddr[2] == dmac_pkg::CSR_WORD_SHIFT) begin
         ws_in = pwdata[0];
      end

      case (state_ff)
         dmac_pkg::S_IDLE: begin
            sel_in = '{hit: 1'b1, ch: req_port[1:0]};
            case (dmac_pkg::cmd_type'(req_command))
               dmac_pkg::CMD_CHAN_WR, dmac_pkg::CMD_CHAN_RD:
                  sel_in = '{hit: !req_port[3], ch: req_port[2:1]};
               dmac_pkg::CMD_CTL_WR:
                  sel_in = '{hit: req_port == dmac_pkg::CTL_MODE, ch: req_write_byte[1:0]};
               dmac_pkg::CMD_PAGE_WR, dmac_pkg::CMD_PAGE_RD,
               dmac_pkg::CMD_HPAGE_WR, dmac_pkg::CMD_HPAGE_RD:
                  sel_in = dmac_pkg::page_map(req_port[2:0]);
               dmac_pkg::CMD_POSITION: ;
               default: sel_in.hit = 1'b0;
            endcase
            rd_addr = sel_in.ch;
            if (start) begin
               cmd_in  = req_command;
               port_in = req_port;
               data_in = req_write_byte;
               pos_in  = req_new_position;
               scan_in = '0;
               if (req_command == dmac_pkg::CMD_TICK) begin
                  if (svc == '0) begin
                     v_in    = 1'b1;
                     last_in = 1'b1;
                  end else begin
                     state_in = dmac_pkg::S_TICK_RD;
                  end
               end else begin
                  state_in = dmac_pkg::S_EXEC;
               end
            end
         end
         dmac_pkg::S_EXEC: begin
            v_in     = 1'b1;
            last_in  = 1'b1;
            state_in = dmac_pkg::S_IDLE;
            case (dmac_pkg::cmd_type'(cmd_ff))
               dmac_pkg::CMD_CHAN_WR: if (sel_ff.hit) begin
                  toggle_in = !toggle_ff;
                  wr_en = 1'b1;
                  if (toggle_ff) begin
                     if (port_ff[0]) wr_rec.base_count[15:8] = data_ff;
                     else wr_rec.base_address[15:8] = data_ff;
                     wr_rec.current_address = 17'({1'b0, wr_rec.base_address} << ws_ff);
                     wr_rec.current_count = '0;
                  end else begin
                     if (port_ff[0]) wr_rec.base_count[7:0] = data_ff;
                     else wr_rec.base_address[7:0] = data_ff;
                  end
               end
               dmac_pkg::CMD_CHAN_RD: if (sel_ff.hit) begin
                  toggle_in = !toggle_ff;
                  if (port_ff[0]) val = 18'({2'b0, rec.base_count} << ws_ff) - rec.current_count;
                  else if (rec.mode[5]) val = {1'b0, rec.current_address} - rec.current_count;
                  else val = {1'b0, rec.current_address} + rec.current_count;
                  rsh = {1'b0, toggle_ff, 3'b0} + {4'b0, ws_ff};
                  rb_in = 8'(val >> rsh);
               end
               dmac_pkg::CMD_CTL_WR: begin
                  case (dmac_pkg::ctl_type'(port_ff))
                     dmac_pkg::CTL_COMMAND:
                        if (data_ff == '0 || (data_ff & dmac_pkg::UNSUPPORTED_CMD) == '0)
                           cmdreg_in = data_ff;
                     dmac_pkg::CTL_REQUEST: begin
                        status_in[{1'b1, data_ff[1:0]}] = data_ff[2];
                        status_in[{1'b0, data_ff[1:0]}] = 1'b0;
                     end
                     dmac_pkg::CTL_SMASK: mask_in[data_ff[1:0]] = data_ff[2];
                     dmac_pkg::CTL_MODE: begin
                        wr_en = 1'b1;
                        wr_rec.mode = data_ff;
                     end
                     dmac_pkg::CTL_CLR_FF: toggle_in = 1'b0;
                     dmac_pkg::CTL_RESET: begin
                        toggle_in = 1'b0;
                        mask_in   = dmac_pkg::MASK_ALL;
                        status_in = '0;
                        cmdreg_in = '0;
                     end
                     dmac_pkg::CTL_CLR_MASK: mask_in = '0;
                     dmac_pkg::CTL_WR_MASK: mask_in = data_ff;
                     default: ;
                  endcase
               end
               dmac_pkg::CMD_CTL_RD: begin
                  if (port_ff == dmac_pkg::CTL_COMMAND) begin
                     rb_in = status_ff;
                     status_in[3:0] = '0;
                  end else if (port_ff == dmac_pkg::CTL_WR_MASK) begin
                     rb_in = mask_ff;
                  end
               end
               dmac_pkg::CMD_PAGE_WR: if (sel_ff.hit) begin
                  wr_en = 1'b1;
                  wr_rec.page_low = data_ff;
               end
               dmac_pkg::CMD_PAGE_RD: if (sel_ff.hit) rb_in = rec.page_low;
               dmac_pkg::CMD_HPAGE_WR: if (sel_ff.hit) begin
                  wr_en = 1'b1;
                  wr_rec.page_high = data_ff;
               end
               dmac_pkg::CMD_HPAGE_RD: if (sel_ff.hit) rb_in = rec.page_high;
               dmac_pkg::CMD_HOLD: status_in[{1'b1, ch2}] = 1'b1;
               dmac_pkg::CMD_RELEASE: status_in[{1'b1, ch2}] = 1'b0;
               dmac_pkg::CMD_POSITION: begin
                  wr_en = 1'b1;
                  wr_rec.current_count = pos_ff;
               end
               default: ;
            endcase
            if (wr_en) mem_ok_in[sel_ff.ch] = 1'b1;
         end
         dmac_pkg::S_TICK_RD: begin
            state_in = dmac_pkg::S_TICK_EX;
         end
         dmac_pkg::S_TICK_EX: begin
            if (svc[scan_ff]) begin
               v_in    = 1'b1;
               tv_in   = 1'b1;
               tc_in   = scan_ff;
               tp_in   = rec.current_count;
               tl_in   = 18'({1'b0, len17} << ws_ff);
               ta_in   = {rec.page_high[6:0], 24'(rec.page_low) << 16}
                         | 31'(rec.current_address);
               dn_in   = rec.mode[5];
               last_in = !more;
            end
            if (!more) begin
               state_in = dmac_pkg::S_IDLE;
            end else begin
               scan_in  = scan_ff + CW'(1);
               state_in = dmac_pkg::S_TICK_RD;
            end
         end
         default: state_in = dmac_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dmac_pkg::S_IDLE;
         ws_ff     <= 1'b0;
         toggle_ff <= 1'b0;
         mask_ff   <= dmac_pkg::MASK_ALL;
         status_ff <= '0;
         cmdreg_ff <= '0;
         mem_ok_ff <= '0;
         v_ff      <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ws_ff     <= ws_in;
         toggle_ff <= toggle_in;
         mask_ff   <= mask_in;
         status_ff <= status_in;
         cmdreg_ff <= cmdreg_in;
         mem_ok_ff <= mem_ok_in;
         v_ff      <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      port_ff <= port_in;
      data_ff <= data_in;
      pos_ff  <= pos_in;
      sel_ff  <= sel_in;
      scan_ff <= scan_in;
      tv_ff   <= tv_in;
      dn_ff   <= dn_in;
      last_ff <= last_in;
      rb_ff   <= rb_in;
      tc_ff   <= tc_in;
      tp_ff   <= tp_in;
      tl_ff   <= tl_in;
      ta_ff   <= ta_in;
   end

   assign busy                  = state_ff != dmac_pkg::S_IDLE;
   assign rsp_valid             = v_ff;
   assign rsp_read_byte         = rb_ff;
   assign rsp_transfer_valid    = tv_ff;
   assign rsp_transfer_channel  = tc_ff;
   assign rsp_transfer_position = tp_ff;
   assign rsp_transfer_length   = tl_ff;
   assign rsp_transfer_address  = ta_ff;
   assign rsp_address_down      = dn_ff;
   assign rsp_last              = last_ff;
   assign pready                = 1'b1;
   assign prdata = (paddr[2] == dmac_pkg::CSR_WORD_SHIFT) ? {31'b0, ws_ff} : '0;

endmodule

// ===== rtl/dmac_checker.sv =====
// Port-level checks for the ISA DMA controller register model.
// Bound to isa_dma_controller_registers; no other dependencies.
module dmac_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [7:0]  rsp_read_byte,
   input logic        rsp_transfer_valid,
   input logic        rsp_last,
   input logic        pready
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy && $past(!busy) |=> busy || rsp_valid)
      else $error("No activity after an accepted transaction.");

   a_idle_result_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_transfer_valid |-> rsp_last)
      else $error("A result without a transfer is not the last.");

   a_tick_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_transfer_valid |-> rsp_valid && rsp_read_byte == 8'd0)
      else $error("Transfer result carries read data or lacks a strobe.");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready dropped.");

endmodule

bind isa_dma_controller_registers dmac_checker u_dmac_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_read_byte(rsp_read_byte),
   .rsp_transfer_valid(rsp_transfer_valid), .rsp_last(rsp_last), .pready(pready)
);
